>>> hw/rtl/ptf_pkg.sv
// Package for the phase-angle triac firing block: register codes, reset
// values, state and configuration structs. No dependencies.
package ptf_pkg;

  localparam int unsigned FireDelayW   = 14;
  localparam int unsigned PulseWidthW  = 8;
  localparam int unsigned DebounceW    = 16;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned CfgIdxW      = 2;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegFireDelay  = 2'd0,
    RegPulseWidth = 2'd1,
    RegDebounce   = 2'd2
  } ptf_reg_e;

  localparam logic [FireDelayW-1:0]  FireDelayRst  = 14'd4000;
  localparam logic [PulseWidthW-1:0] PulseWidthRst = 8'd50;
  localparam logic [DebounceW-1:0]   DebounceRst   = 16'd1000;
  localparam logic [DebounceW-1:0]   AgeMax        = '1;

  typedef struct packed {
    logic [FireDelayW-1:0]  fire_delay;
    logic [PulseWidthW-1:0] pulse_width;
    logic [DebounceW-1:0]   debounce_window;
  } ptf_cfg_t;

  typedef struct packed {
    logic                   prev_level;
    logic [DebounceW-1:0]   edge_age;
    logic [FireDelayW-1:0]  delay_count;
    logic                   delay_running;
    logic [PulseWidthW-1:0] pulse_left;
  } ptf_state_t;

  typedef struct packed {
    logic gate;
    logic edge_accepted;
  } ptf_result_t;

endpackage

>>> hw/rtl/ptf_ifs.sv
// Handshake interfaces of the triac firing block: tick input, result
// output and configuration write channel. Depends on ptf_pkg.
interface ptf_in_if;
  logic valid;
  logic ready;
  logic zc_level;
  modport source (output valid, output zc_level, input ready);
  modport sink   (input valid, input zc_level, output ready);
endinterface

interface ptf_out_if;
  logic valid;
  logic ready;
  logic gate;
  logic edge_accepted;
  modport source (output valid, output gate, output edge_accepted, input ready);
  modport sink   (input valid, input gate, input edge_accepted, output ready);
endinterface

interface ptf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptf_pkg::CfgIdxW-1:0]   index;
  logic [ptf_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ptf_step.sv
// One-tick update of the firing state: edge detect, debounce, delay count
// and gate pulse. Purely combinational. Depends on ptf_pkg.
module ptf_step (
  input  logic                 zc_level_i,
  input  ptf_pkg::ptf_cfg_t    cfg_i,
  input  ptf_pkg::ptf_state_t  state_i,
  output ptf_pkg::ptf_state_t  state_o,
  output ptf_pkg::ptf_result_t result_o
);

  logic [ptf_pkg::DebounceW-1:0]   age_now;
  logic                            rising;
  logic                            accepted;
  logic                            fire;
  logic [ptf_pkg::FireDelayW-1:0]  count_inc;
  logic [ptf_pkg::PulseWidthW-1:0] pulse_now;

  // Saturating edge age and debounce check
  assign age_now  = (state_i.edge_age == ptf_pkg::AgeMax) ? state_i.edge_age
                                                          : state_i.edge_age + 1'b1;
  assign rising   = zc_level_i & ~state_i.prev_level;
  assign accepted = rising && (age_now >= cfg_i.debounce_window);
  assign count_inc = state_i.delay_count + 1'b1;

  always_comb begin
    state_o            = state_i;
    state_o.prev_level = zc_level_i;
    state_o.edge_age   = rising ? '0 : age_now;
    fire               = 1'b0;

    // Delay count; an edge during a running delay leaves it alone
    if (state_i.delay_running) begin
      state_o.delay_count = count_inc;
      fire = (count_inc >= cfg_i.fire_delay);
    end else if (accepted) begin
      state_o.delay_count = '0;
      if (cfg_i.fire_delay == '0) begin
        fire = 1'b1;
      end else begin
        state_o.delay_running = 1'b1;
      end
    end

    if (fire) begin
      state_o.delay_running = 1'b0;
    end
    pulse_now = fire ? cfg_i.pulse_width : state_i.pulse_left;

    // Gate pulse countdown
    result_o.gate          = (pulse_now != '0);
    result_o.edge_accepted = accepted;
    state_o.pulse_left     = (pulse_now != '0) ? pulse_now - 1'b1 : pulse_now;
  end

endmodule

>>> hw/rtl/phase_angle_triac_firing_top.sv
// Top level of the phase-angle triac firing block: input register, state,
// configuration registers and result register. Depends on ptf_pkg, ptf_ifs, ptf_step.
//
//  channel  dir  fields                  accepted when
//  in_i     in   zc_level                in_i.valid  && in_i.ready
//  out_o    out  gate, edge_accepted     out_o.valid && out_o.ready
//  cfg_i    in   index, data             cfg_i.valid && cfg_i.ready (always ready)
//
// One tick per cycle sustained while out_o does not stall; a tick taken into the input register
// passes through the combinational state update into the result register when the result
// register is empty or being read, and out_o.valid rises as it is loaded.
// Reset puts the configuration and the firing state at their defaults and empties both registers.
// When out_o stalls, an empty input register still takes one more tick, then
// in_i.ready drops until the result is taken.
module phase_angle_triac_firing_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptf_in_if.sink      in_i,
  ptf_out_if.source   out_o,
  ptf_cfg_if.sink     cfg_i
);

  ptf_pkg::ptf_cfg_t    cfg_q;
  ptf_pkg::ptf_state_t  state_q, state_d;
  ptf_pkg::ptf_result_t result_d, result_q;
  logic                 in_valid_q;
  logic                 zc_q;
  logic                 out_valid_q;
  logic                 advance;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fire_delay      <= ptf_pkg::FireDelayRst;
      cfg_q.pulse_width     <= ptf_pkg::PulseWidthRst;
      cfg_q.debounce_window <= ptf_pkg::DebounceRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ptf_pkg::RegFireDelay:  cfg_q.fire_delay  <= cfg_i.data[ptf_pkg::FireDelayW-1:0];
        ptf_pkg::RegPulseWidth: cfg_q.pulse_width <= cfg_i.data[ptf_pkg::PulseWidthW-1:0];
        ptf_pkg::RegDebounce:   cfg_q.debounce_window <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      zc_q <= in_i.zc_level;
    end
  end

  ptf_step u_step (
    .zc_level_i (zc_q),
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // Firing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prev_level    <= 1'b0;
      state_q.edge_age      <= ptf_pkg::AgeMax;
      state_q.delay_count   <= '0;
      state_q.delay_running <= 1'b0;
      state_q.pulse_left    <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.gate          = result_q.gate;
  assign out_o.edge_accepted = result_q.edge_accepted;

endmodule

>>> hw/rtl/ptf_checker.sv
// Port-level checker for the triac firing block, bound to the top level.
// Depends on phase_angle_triac_firing_top and ptf_ifs.
module ptf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_gate_i,
  input logic out_edge_accepted_i
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] fill_q;
  logic       last_acc_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Items inside the block, and last delivered edge flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      last_acc_q <= 1'b0;
    end else begin
      fill_q <= fill_q + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire) begin
        last_acc_q <= out_edge_accepted_i;
      end
    end
  end

  // Never more than two items held
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("more than two items in flight");

  // A result only for an item taken earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_i |-> fill_q != 2'd0)
    else $error("result without an item");

  // Two accepted edges in a row need a falling level in between
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_fire && out_edge_accepted_i |-> !last_acc_q)
    else $error("edge accepted on consecutive ticks");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_gate_i)
                   && $stable(out_edge_accepted_i))
    else $error("stalled result changed");

endmodule

bind phase_angle_triac_firing_top ptf_checker u_ptf_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_gate_i          (out_o.gate),
  .out_edge_accepted_i (out_o.edge_accepted)
);

>>> tb/ptf_firing_checker.sv
// Checker for the triac firing block: predicts gate and edge-accept bits per tick
// and compares them with the result channel. Depends on ptf_pkg.
module ptf_firing_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_valid_i,
  input  logic                         tick_ready_i,
  input  logic                         tick_level_i,
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  input  logic                         res_gate_i,
  input  logic                         res_edge_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [ptf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ptf_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  results_due_o,
  output int unsigned                  mismatches_o
);

  ptf_pkg::ptf_cfg_t    regs;
  ptf_pkg::ptf_state_t  timing;
  ptf_pkg::ptf_result_t firing_q[$];
  int unsigned          mismatch_cnt;

  assign results_due_o = firing_q.size();
  assign mismatches_o  = mismatch_cnt;

  // one line per mismatch; printing is capped to keep a broken run readable
  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 40) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  // advance the firing timer by one tick and return the expected result item
  function automatic ptf_pkg::ptf_result_t predict_tick(input logic lvl);
    ptf_pkg::ptf_result_t          r;
    logic [ptf_pkg::DebounceW-1:0] age;
    logic                          rising;
    logic                          fire;
    r    = '0;
    fire = 1'b0;
    age  = timing.edge_age;
    if (age != ptf_pkg::AgeMax) age = age + 1'b1;
    rising = lvl && !timing.prev_level;
    // any rising edge restarts the age, accepted or not
    if (rising) begin
      r.edge_accepted = (age >= regs.debounce_window);
      timing.edge_age = '0;
    end else begin
      timing.edge_age = age;
    end
    timing.prev_level = lvl;
    // an accepted edge does not restart a delay already running
    if (timing.delay_running) begin
      timing.delay_count = timing.delay_count + 1'b1;
      if (timing.delay_count >= regs.fire_delay) fire = 1'b1;
    end else if (r.edge_accepted) begin
      timing.delay_count = '0;
      if (regs.fire_delay == '0) fire = 1'b1;
      else timing.delay_running = 1'b1;
    end
    if (fire) begin
      timing.delay_running = 1'b0;
      timing.pulse_left    = regs.pulse_width;
    end
    if (timing.pulse_left != '0) begin
      r.gate = 1'b1;
      timing.pulse_left = timing.pulse_left - 1'b1;
    end
    return r;
  endfunction

  // watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    ptf_pkg::ptf_result_t want;
    if (!rst_ni) begin
      regs.fire_delay      = ptf_pkg::FireDelayRst;
      regs.pulse_width     = ptf_pkg::PulseWidthRst;
      regs.debounce_window = ptf_pkg::DebounceRst;
      timing.prev_level    = 1'b0;
      timing.edge_age      = ptf_pkg::AgeMax;
      timing.delay_count   = '0;
      timing.delay_running = 1'b0;
      timing.pulse_left    = '0;
      firing_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ptf_pkg::RegFireDelay:
            regs.fire_delay      = cfg_data_i[ptf_pkg::FireDelayW-1:0];
          ptf_pkg::RegPulseWidth:
            regs.pulse_width     = cfg_data_i[ptf_pkg::PulseWidthW-1:0];
          ptf_pkg::RegDebounce:
            regs.debounce_window = cfg_data_i[ptf_pkg::DebounceW-1:0];
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) begin
        firing_q.push_back(predict_tick(tick_level_i));
      end
      if (res_valid_i && res_ready_i) begin
        if (firing_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = firing_q.pop_front();
          if (res_gate_i !== want.gate) begin
            report_mismatch($sformatf("gate %b, expected %b", res_gate_i, want.gate));
          end
          if (res_edge_i !== want.edge_accepted) begin
            report_mismatch($sformatf("edge_accepted %b, expected %b",
                                      res_edge_i, want.edge_accepted));
          end
        end
      end
    end
  end

  initial mismatch_cnt = 0;

endmodule

>>> tb/tb_phase_angle_triac_firing_top.sv
// Testbench top for phase_angle_triac_firing_top: drives ticks and register
// writes, stalls both sides, gives the verdict. Depends on ptf_pkg, ptf_ifs, checker.
module tb_phase_angle_triac_firing_top;

  localparam logic [ptf_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned                 HoldTicks = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  ptf_in_if  tick_if ();
  ptf_out_if res_if ();
  ptf_cfg_if cfg_if ();

  int unsigned results_due;
  int unsigned mismatches;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  logic        hold_req = 1'b0;

  phase_angle_triac_firing_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  ptf_firing_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_valid_i  (tick_if.valid),
    .tick_ready_i  (tick_if.ready),
    .tick_level_i  (tick_if.zc_level),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_gate_i    (res_if.gate),
    .res_edge_i    (res_if.edge_accepted),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_index_i   (cfg_if.index),
    .cfg_data_i    (cfg_if.data),
    .results_due_o (results_due),
    .mismatches_o  (mismatches)
  );

  // clock, period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard limit on the run
  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    logic        hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldTicks;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // offer one tick item, with random idle cycles ahead of it
  task automatic send_tick(input logic lvl);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid    <= 1'b1;
    tick_if.zc_level <= lvl;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  // drop valid and wait until every expected result item has come
  task automatic settle();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ptf_pkg::CfgIdxW-1:0] idx,
                           input logic [ptf_pkg::CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // zero-cross square wave with random half periods, mixed with bounce noise
  task automatic run_phase(input int unsigned n, input int unsigned span);
    logic        level_now;
    logic        lvl;
    int unsigned run_left;
    level_now = 1'b0;
    run_left  = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        lvl = 1'($urandom_range(0, 1));
      end else begin
        if (run_left == 0) begin
          level_now = ~level_now;
          run_left  = $urandom_range(1, span);
        end
        run_left--;
        lvl = level_now;
      end
      send_tick(lvl);
    end
    settle();
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int unsigned fd;
    int unsigned pw;
    int unsigned db;
    int unsigned span;
    rst_ni           <= 1'b0;
    tick_if.valid    <= 1'b0;
    tick_if.zc_level <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= ptf_pkg::RegFireDelay;
    cfg_if.data      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // defaults: first edge accepted, an early repeat edge rejected
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0);
    send_tick(1'b1); send_tick(1'b1); send_tick(1'b0);
    settle();

    // zero delay fires on the accept tick; an edge during the pulse refires it
    write_reg(ptf_pkg::RegFireDelay, 16'hC000);
    write_reg(ptf_pkg::RegPulseWidth, 16'h0003);
    write_reg(ptf_pkg::RegDebounce, 16'h0000);
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
    repeat (5) send_tick(1'b1);
    settle();

    // edge while the delay runs is ignored; zero pulse width gives no gate
    write_reg(ptf_pkg::RegFireDelay, 16'h0003);
    write_reg(ptf_pkg::RegPulseWidth, 16'hFF00);
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0);
    send_tick(1'b1); send_tick(1'b0); send_tick(1'b0);
    settle();

    // unused index ignored; delay lowered below the running count
    write_reg(RegUnused, 16'hFFFF);
    write_reg(ptf_pkg::RegFireDelay, 16'd20);
    write_reg(ptf_pkg::RegPulseWidth, 16'd2);
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0); send_tick(1'b0);
    settle();
    write_reg(ptf_pkg::RegFireDelay, 16'd1);
    send_tick(1'b0); send_tick(1'b0); send_tick(1'b0);
    settle();

    // random phases under every idling mode, extremes in two of them
    for (int unsigned p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      if (p == 2) begin
        fd = 16383; pw = 255; db = 65535;
      end else if (p == 5) begin
        fd = 0; pw = 1; db = 0;
      end else begin
        fd = $urandom_range(0, 24);
        pw = $urandom_range(0, 12);
        db = $urandom_range(0, 20);
      end
      write_reg(ptf_pkg::RegFireDelay, {2'($urandom_range(0, 3)), 14'(fd)});
      write_reg(ptf_pkg::RegPulseWidth, {8'($urandom_range(0, 255)), 8'(pw)});
      write_reg(ptf_pkg::RegDebounce, 16'(db));
      if ($urandom_range(0, 2) == 0) write_reg(RegUnused, 16'($urandom_range(0, 65535)));
      span = (db > 30) ? 64 : db * 2 + 4;
      run_phase(45, span);
    end

    // long receiver hold-off while ticks keep coming, so the input stalls
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_reg(ptf_pkg::RegFireDelay, 16'd6);
    write_reg(ptf_pkg::RegPulseWidth, 16'd4);
    write_reg(ptf_pkg::RegDebounce, 16'd3);
    hold_req = 1'b1;
    run_phase(60, 10);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
